/* hdl/uvs_pkg.sv */
package uvs_pkg;

    // Register and field widths
    localparam int unsigned CountWidth = 9;
    localparam int unsigned IndexWidth = 17;
    localparam int unsigned PartWidth  = 2;
    localparam int unsigned CfgAddrWidth = 2;

    // Register limits
    localparam logic [CountWidth-1:0] SliceMin = 9'd3;
    localparam logic [CountWidth-1:0] SliceMax = 9'd256;
    localparam logic [CountWidth-1:0] StackMin = 9'd2;
    localparam logic [CountWidth-1:0] StackMax = 9'd256;

    localparam logic [CountWidth-1:0] SliceReset = 9'd16;
    localparam logic [CountWidth-1:0] StackReset = 9'd8;
    // (8+1)*(16+1) and (8-1)*(16+1)
    localparam logic [IndexWidth-1:0] VertexTotalReset = 17'd153;
    localparam logic [IndexWidth-1:0] SouthBaseReset   = 17'd119;

    // Register indexes
    localparam logic [CfgAddrWidth-1:0] CfgSliceCount = 2'd0;
    localparam logic [CfgAddrWidth-1:0] CfgStackCount = 2'd1;

    // Output part codes
    localparam logic [PartWidth-1:0] PartCodeNorth = 2'd0;
    localparam logic [PartWidth-1:0] PartCodeBody  = 2'd1;
    localparam logic [PartWidth-1:0] PartCodeSouth = 2'd2;

    // Walk phase
    typedef enum logic [2:0] {
        PH_NORTH = 3'b001,
        PH_BODY  = 3'b010,
        PH_SOUTH = 3'b100
    } phase_t;

    // Corner codes; in the body CORNER_RESTART marks the strip break
    localparam logic [1:0] CornerFirst   = 2'd0;
    localparam logic [1:0] CornerSecond  = 2'd1;
    localparam logic [1:0] CornerThird   = 2'd2;
    localparam logic [1:0] CornerRestart = 2'd2;

endpackage

/* hdl/uvs_in_if.sv */
interface uvs_in_if;
    logic valid;
    logic ready;
    logic start_new;

    modport source (output valid, output start_new, input ready);
    modport sink   (input valid, input start_new, output ready);
endinterface

/* hdl/uvs_out_if.sv */
interface uvs_out_if;
    logic                             valid;
    logic                             ready;
    logic [uvs_pkg::IndexWidth-1:0]   vertex_index;
    logic                             is_restart;
    logic [uvs_pkg::PartWidth-1:0]    part;
    logic                             last_index;

    modport source (output valid, output vertex_index, output is_restart,
                    output part, output last_index, input ready);
    modport sink   (input valid, input vertex_index, input is_restart,
                    input part, input last_index, output ready);
endinterface

/* hdl/uv_sphere_index_generator_top.sv */
// UV sphere index generator. Each transfer on the step channel yields exactly
// one transfer on the result channel carrying the next entry of the sphere's
// index list: north cap triangles (3 per slice), body triangle strips with a
// restart entry (value = vertex count) between strips, then south cap
// triangles (3 per slice). start_new = 1 restarts the list and returns its
// first entry. One entry per clock while result.ready holds: the walk counters
// and the index adder sit between the counter registers and a single result
// register, and the step channel stays ready while that register is empty or
// being drained, so each entry shows in the cycle after its step transfer.
// Configuration writes (slice_count at index 0, stack_count at index 1,
// saturated to 3..256 and 2..256) restart the walk; they must be issued only
// while no result is outstanding. Writes to other indexes are ignored.
module uv_sphere_index_generator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [uvs_pkg::CfgAddrWidth-1:0]  cfg_addr,
    input  logic [uvs_pkg::CountWidth-1:0]    cfg_wdata,
    uvs_in_if.sink                            step,
    uvs_out_if.source                         result
);

    // ------------------------------------------------------------------
    // Configuration registers plus the two derived totals. The products
    // are taken at write time so the walk never sees a multiplier.
    // ------------------------------------------------------------------
    logic [uvs_pkg::CountWidth-1:0] slice_reg, slice_next;
    logic [uvs_pkg::CountWidth-1:0] stack_reg, stack_next;
    logic [uvs_pkg::IndexWidth-1:0] vtotal_reg, vtotal_next;
    logic [uvs_pkg::IndexWidth-1:0] sbase_reg, sbase_next;

    logic [uvs_pkg::CountWidth-1:0] sat_slice, sat_stack;
    logic                           cfg_hit;
    logic [uvs_pkg::CountWidth:0]   slice_p1_w, stack_p1_w, stack_m1_w;
    logic [2*uvs_pkg::CountWidth+1:0] vtotal_prod, sbase_prod;

    always_comb
    begin
        sat_slice = cfg_wdata;
        if (cfg_wdata < uvs_pkg::SliceMin)
            sat_slice = uvs_pkg::SliceMin;
        else if (cfg_wdata > uvs_pkg::SliceMax)
            sat_slice = uvs_pkg::SliceMax;

        sat_stack = cfg_wdata;
        if (cfg_wdata < uvs_pkg::StackMin)
            sat_stack = uvs_pkg::StackMin;
        else if (cfg_wdata > uvs_pkg::StackMax)
            sat_stack = uvs_pkg::StackMax;

        slice_next = slice_reg;
        stack_next = stack_reg;
        cfg_hit    = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                uvs_pkg::CfgSliceCount:
                begin
                    slice_next = sat_slice;
                    cfg_hit    = 1'b1;
                end
                uvs_pkg::CfgStackCount:
                begin
                    stack_next = sat_stack;
                    cfg_hit    = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        slice_p1_w  = {1'b0, slice_next} + 10'd1;
        stack_p1_w  = {1'b0, stack_next} + 10'd1;
        stack_m1_w  = {1'b0, stack_next} - 10'd1;
        vtotal_prod = stack_p1_w * slice_p1_w;
        sbase_prod  = stack_m1_w * slice_p1_w;
        vtotal_next = vtotal_prod[uvs_pkg::IndexWidth-1:0];
        sbase_next  = sbase_prod[uvs_pkg::IndexWidth-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg  <= uvs_pkg::SliceReset;
            stack_reg  <= uvs_pkg::StackReset;
            vtotal_reg <= uvs_pkg::VertexTotalReset;
            sbase_reg  <= uvs_pkg::SouthBaseReset;
        end
        else if (cfg_hit)
        begin
            slice_reg  <= slice_next;
            stack_reg  <= stack_next;
            vtotal_reg <= vtotal_next;
            sbase_reg  <= sbase_next;
        end
    end

    // ------------------------------------------------------------------
    // Walk state
    // ------------------------------------------------------------------
    uvs_pkg::phase_t                phase_reg, phase_next, ph;
    logic [uvs_pkg::CountWidth-1:0] ring_reg, ring_next, ring;
    logic [uvs_pkg::CountWidth-1:0] slc_reg, slc_next, slc;
    logic [1:0]                     corner_reg, corner_next, corner;
    logic [uvs_pkg::IndexWidth-1:0] base_reg, base_next, base;

    // result register
    logic                           out_valid_reg;
    logic [uvs_pkg::IndexWidth-1:0] idx_reg, idx_next;
    logic                           rst_flag_reg, rst_flag_next;
    logic [uvs_pkg::PartWidth-1:0]  part_reg, part_next;
    logic                           last_reg, last_next;

    logic step_xfer;
    logic [uvs_pkg::CountWidth:0]   s_p1, s_p2, slc_inc;
    logic [uvs_pkg::CountWidth-1:0] ring_inc, stack_m2;
    logic [uvs_pkg::IndexWidth-1:0] s_p1_x, s_p2_x, slc_x;

    assign step.ready = !out_valid_reg || result.ready;
    assign step_xfer  = step.valid && step.ready;

    always_comb
    begin
        // start_new restarts the walk before this entry is produced
        if (step.start_new)
        begin
            ph     = uvs_pkg::PH_NORTH;
            ring   = '0;
            slc    = '0;
            corner = uvs_pkg::CornerFirst;
            base   = '0;
        end
        else
        begin
            ph     = phase_reg;
            ring   = ring_reg;
            slc    = slc_reg;
            corner = corner_reg;
            base   = base_reg;
        end

        s_p1     = {1'b0, slice_reg} + 10'd1;
        s_p2     = {1'b0, slice_reg} + 10'd2;
        slc_inc  = {1'b0, slc} + 10'd1;
        ring_inc = ring + 9'd1;
        stack_m2 = stack_reg - 9'd2;
        s_p1_x   = {{(uvs_pkg::IndexWidth-uvs_pkg::CountWidth-1){1'b0}}, s_p1};
        s_p2_x   = {{(uvs_pkg::IndexWidth-uvs_pkg::CountWidth-1){1'b0}}, s_p2};
        slc_x    = {{(uvs_pkg::IndexWidth-uvs_pkg::CountWidth){1'b0}}, slc};

        // entry value
        rst_flag_next = 1'b0;
        last_next     = 1'b0;
        idx_next      = base + slc_x;
        part_next     = uvs_pkg::PartCodeNorth;
        unique case (ph)
            uvs_pkg::PH_NORTH:
            begin
                part_next = uvs_pkg::PartCodeNorth;
                if (corner == uvs_pkg::CornerSecond)
                    idx_next = slc_x + s_p1_x;
                else if (corner == uvs_pkg::CornerThird)
                    idx_next = slc_x + s_p2_x;
                else
                    idx_next = slc_x;
            end
            uvs_pkg::PH_BODY:
            begin
                part_next = uvs_pkg::PartCodeBody;
                if (corner == uvs_pkg::CornerRestart)
                begin
                    idx_next      = vtotal_reg;
                    rst_flag_next = 1'b1;
                end
                else if (corner == uvs_pkg::CornerSecond)
                    idx_next = base + slc_x + s_p1_x;
            end
            uvs_pkg::PH_SOUTH:
            begin
                part_next = uvs_pkg::PartCodeSouth;
                if (corner == uvs_pkg::CornerSecond)
                    idx_next = base + slc_x + 17'd1;
                else if (corner == uvs_pkg::CornerThird)
                    idx_next = base + slc_x + s_p1_x;
                last_next = (slc_inc == {1'b0, slice_reg})
                            && (corner == uvs_pkg::CornerThird);
            end
            default:
            begin
                part_next = uvs_pkg::PartCodeNorth;
            end
        endcase

        // advance
        phase_next  = ph;
        ring_next   = ring;
        slc_next    = slc;
        corner_next = corner;
        base_next   = base;
        if (ph == uvs_pkg::PH_BODY)
        begin
            if (corner == uvs_pkg::CornerRestart)
                corner_next = uvs_pkg::CornerFirst;
            else if (corner == uvs_pkg::CornerFirst)
                corner_next = uvs_pkg::CornerSecond;
            else
            begin
                corner_next = uvs_pkg::CornerFirst;
                slc_next    = slc_inc[uvs_pkg::CountWidth-1:0];
                if (slc_inc > {1'b0, slice_reg})
                begin
                    // strip done: next ring pair or south cap
                    slc_next  = '0;
                    ring_next = ring_inc;
                    base_next = base + s_p1_x;
                    if (ring_inc >= stack_m2)
                    begin
                        phase_next = uvs_pkg::PH_SOUTH;
                        base_next  = sbase_reg;
                    end
                    else
                        corner_next = uvs_pkg::CornerRestart;
                end
            end
        end
        else if (corner != uvs_pkg::CornerThird)
            corner_next = corner + 2'd1;
        else
        begin
            corner_next = uvs_pkg::CornerFirst;
            slc_next    = slc_inc[uvs_pkg::CountWidth-1:0];
            if (slc_inc >= {1'b0, slice_reg})
            begin
                slc_next = '0;
                if (ph == uvs_pkg::PH_NORTH)
                begin
                    if (stack_reg > uvs_pkg::StackMin)
                    begin
                        phase_next = uvs_pkg::PH_BODY;
                        ring_next  = '0;
                        base_next  = s_p1_x;
                    end
                    else
                    begin
                        // two stacks: no body
                        phase_next = uvs_pkg::PH_SOUTH;
                        base_next  = sbase_reg;
                    end
                end
                else
                begin
                    // end of list: wrap
                    phase_next = uvs_pkg::PH_NORTH;
                    ring_next  = '0;
                    base_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= uvs_pkg::PH_NORTH;
            ring_reg      <= '0;
            slc_reg       <= '0;
            corner_reg    <= uvs_pkg::CornerFirst;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_hit)
            begin
                // register write restarts the walk
                phase_reg  <= uvs_pkg::PH_NORTH;
                ring_reg   <= '0;
                slc_reg    <= '0;
                corner_reg <= uvs_pkg::CornerFirst;
                base_reg   <= '0;
            end
            else if (step_xfer)
            begin
                phase_reg  <= phase_next;
                ring_reg   <= ring_next;
                slc_reg    <= slc_next;
                corner_reg <= corner_next;
                base_reg   <= base_next;
            end

            if (step_xfer)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (step_xfer)
        begin
            idx_reg      <= idx_next;
            rst_flag_reg <= rst_flag_next;
            part_reg     <= part_next;
            last_reg     <= last_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.vertex_index = idx_reg;
    assign result.is_restart   = rst_flag_reg;
    assign result.part         = part_reg;
    assign result.last_index   = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_restart_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rst_flag_reg) |-> (part_reg == uvs_pkg::PartCodeBody))
        else $error("restart entry outside body");

    a_last_in_south: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (part_reg == uvs_pkg::PartCodeSouth))
        else $error("last entry outside south cap");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (phase_reg == uvs_pkg::PH_NORTH && corner_reg == uvs_pkg::CornerFirst
                     && slc_reg == '0 && base_reg == '0))
        else $error("config write did not restart walk");

    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (sbase_reg + {7'd0, slice_reg, 1'b0} + 17'd2) == vtotal_reg)
        else $error("south base and vertex total disagree");

    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        corner_reg != 2'd3)
        else $error("corner counter out of range");

endmodule
